>>> design/hbs_pkg.sv
// Shared types and constants for the 3x3 heightmap box smoothing filter.
`timescale 1ns / 1ps

package hbs_pkg;

	localparam int HEIGHT_W = 16;   // input sample
	localparam int MEAN_W = 24;     // unsigned 16.8 mean
	localparam int ROW_W = 9;       // out_row field
	localparam int COL_W = 9;       // out_col field
	localparam int CFG_W = 10;      // frame_width / frame_height registers
	localparam int CFG_IDX_W = 4;
	localparam int CMP_W = 14;      // common width for position compares
	localparam int SUM_W = 20;      // up to 9 samples
	localparam int CNT_W = 4;       // neighbourhood size, 1..9
	localparam int FRAC_W = 9;      // sum * 512 + n, low bits hold n
	localparam int NUM_W = SUM_W + FRAC_W;
	localparam int X_W = NUM_W - 1; // after the power-of-two part of 2n
	localparam int RECIP_W = 32;
	localparam int PROD_W = X_W + RECIP_W;
	localparam int RECIP_SHIFT = 33;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_PAD_W = OUT_DATA_W - MEAN_W - ROW_W - COL_W;
	localparam int FRAME_DEFAULT = 464;

	localparam logic [RECIP_W-1:0] RECIP_3 = 32'hAAAA_AAAB;
	localparam logic [RECIP_W-1:0] RECIP_9 = 32'h38E3_8E39;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

	// which neighbours lie inside the frame
	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
	} mask_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} tag_t;

	typedef struct packed {
		logic  flush;
		logic  emit;
		mask_t mask;
		tag_t  tag;
	} item_t;

endpackage

>>> design/hbs_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module hbs_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH = 512,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/hbs_window.sv
// Line store read-modify-write, 3x3 window and masked neighbourhood sum.
`timescale 1ns / 1ps

module hbs_window import hbs_pkg::*; #(
	parameter int DEPTH = 512,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  item_t               in_item,
	input  logic [ADDR_W-1:0]   in_addr,
	input  logic [HEIGHT_W-1:0] in_height,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SUM_W-1:0]    out_sum,
	output logic [CNT_W-1:0]    out_cnt,
	output tag_t                out_tag
);

	localparam int WORD_W = 2 * HEIGHT_W;

	logic                v_s1;
	item_t               item_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [HEIGHT_W-1:0] height_s1;
	logic                fwd_s1;
	logic [WORD_W-1:0]   fwd_word_s1;

	logic  v_s2;
	mask_t mask_s2;
	tag_t  tag_s2;

	logic [2:0][2:0][HEIGHT_W-1:0] window_q; // [row][col], col 2 newest

	logic go2, fire1, rd_en;
	logic [WORD_W-1:0] rd_word, cur_word, new_word;
	logic [2:0][HEIGHT_W-1:0] column;
	logic [2:0] row_en, col_en;
	logic [1:0] rows, cols;

	assign go2 = !v_s2 || out_ready;
	assign fire1 = v_s1 && go2;
	assign in_ready = !v_s1 || go2;
	assign rd_en = in_valid && in_ready;

	// store word is {upper row, middle row}; a same-address write in the
	// read cycle is bypassed through fwd_word_s1
	always_comb begin
		cur_word = fwd_s1 ? fwd_word_s1 : rd_word;
		column[0] = cur_word[WORD_W-1:HEIGHT_W];
		column[1] = cur_word[HEIGHT_W-1:0];
		column[2] = item_s1.flush ? '0 : height_s1;
		new_word = {column[1], column[2]};
	end

	hbs_ram #(
		.DATA_W(WORD_W),
		.DEPTH (DEPTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (fire1),
		.wr_addr(addr_s1),
		.wr_data(new_word),
		.rd_en  (rd_en),
		.rd_addr(in_addr),
		.rd_data(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (rd_en) begin
			v_s1 <= 1'b1;
			fwd_s1 <= fire1 && (addr_s1 == in_addr);
		end else if (fire1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			item_s1 <= in_item;
			addr_s1 <= in_addr;
			height_s1 <= in_height;
			fwd_word_s1 <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			window_q <= '0;
		end else begin
			if (go2) begin
				v_s2 <= fire1 && item_s1.emit;
			end
			if (fire1) begin
				for (int r = 0; r < 3; r++) begin
					window_q[r][0] <= window_q[r][1];
					window_q[r][1] <= window_q[r][2];
					window_q[r][2] <= column[r];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			mask_s2 <= item_s1.mask;
			tag_s2 <= item_s1.tag;
		end
	end

	always_comb begin
		row_en = {mask_s2.bot, 1'b1, mask_s2.top};
		col_en = {mask_s2.right, 1'b1, mask_s2.left};
		rows = 2'd1 + {1'b0, mask_s2.top} + {1'b0, mask_s2.bot};
		cols = 2'd1 + {1'b0, mask_s2.left} + {1'b0, mask_s2.right};
		out_cnt = CNT_W'(rows) * CNT_W'(cols);
		out_sum = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_en[r] && col_en[c]) begin
					out_sum = out_sum + SUM_W'(window_q[r][c]);
				end
			end
		end
	end

	assign out_valid = v_s2;
	assign out_tag = tag_s2;

	a_fwd_on_collision: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && fire1 && (in_addr == addr_s1) |=> fwd_s1)
		else $error("line store collision not forwarded");

	a_window_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> $stable(window_q))
		else $error("window shifted under a stalled sum");

endmodule

>>> design/hbs_mean.sv
// Rounded mean: sum * 256 / n by shift and reciprocal multiply, stages s3, s4 and output.
`timescale 1ns / 1ps

module hbs_mean import hbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SUM_W-1:0]  in_sum,
	input  logic [CNT_W-1:0]  in_cnt,
	input  tag_t              in_tag,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MEAN_W-1:0] out_mean,
	output tag_t              out_tag
);

	logic             v_s3;
	logic [SUM_W-1:0] sum_s3;
	logic [CNT_W-1:0] cnt_s3;
	tag_t             tag_s3;

	logic              v_s4;
	logic [X_W-1:0]    x_s4;
	logic [PROD_W-1:0] prod_s4;
	logic              pass_s4;
	tag_t              tag_s4;

	logic              v_q;
	logic [MEAN_W-1:0] mean_q;
	tag_t              tag_q;

	logic go_o, go4, fire3, fire4;
	logic [NUM_W-1:0] num;
	logic [1:0] k;
	logic [RECIP_W-1:0] recip;
	logic pass;
	logic [X_W-1:0] x;

	assign go_o = !v_q || out_ready;
	assign go4 = !v_s4 || go_o;
	assign in_ready = !v_s3 || go4;
	assign fire3 = v_s3 && go4;
	assign fire4 = v_s4 && go_o;

	// (512*sum + n) / 2n: shift out the power of two of 2n, then divide by 1, 3 or 9
	always_comb begin
		num = {sum_s3, FRAC_W'(cnt_s3)};
		unique case (cnt_s3)
			4'd1: begin k = 2'd1; recip = '0; pass = 1'b1; end
			4'd2: begin k = 2'd2; recip = '0; pass = 1'b1; end
			4'd3: begin k = 2'd1; recip = RECIP_3; pass = 1'b0; end
			4'd4: begin k = 2'd3; recip = '0; pass = 1'b1; end
			4'd6: begin k = 2'd2; recip = RECIP_3; pass = 1'b0; end
			4'd9: begin k = 2'd1; recip = RECIP_9; pass = 1'b0; end
			default: begin k = 2'd1; recip = '0; pass = 1'b1; end
		endcase
		x = X_W'(num >> k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s3 <= in_valid;
			end
			if (go4) begin
				v_s4 <= v_s3;
			end
			if (go_o) begin
				v_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sum_s3 <= in_sum;
			cnt_s3 <= in_cnt;
			tag_s3 <= in_tag;
		end
		if (fire3) begin
			x_s4 <= x;
			prod_s4 <= PROD_W'(x) * PROD_W'(recip);
			pass_s4 <= pass;
			tag_s4 <= tag_s3;
		end
		if (fire4) begin
			mean_q <= pass_s4 ? MEAN_W'(x_s4) : prod_s4[RECIP_SHIFT +: MEAN_W];
			tag_q <= tag_s4;
		end
	end

	assign out_valid = v_q;
	assign out_mean = mean_q;
	assign out_tag = tag_q;

	a_cnt_legal: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> (in_cnt == 4'd1 || in_cnt == 4'd2 || in_cnt == 4'd3 ||
			in_cnt == 4'd4 || in_cnt == 4'd6 || in_cnt == 4'd9))
		else $error("neighbourhood size has no divisor");

endmodule

>>> design/heightmap_box_smooth_3x3.sv
// Top level of the streaming 3x3 box mean over a heightmap frame.
// A result passes the line store read, window, s3, s4 and output registers after the beat completing its window;
// results trail the input by frame_width+1 beats and are drained by flush beats.
// Throughput: one beat per cycle unless the output stalls, set by the line store read-modify-write with bypass.
// Reset: counters cleared, frame size 464 x 464; line store is not cleared.
`timescale 1ns / 1ps

module heightmap_box_smooth_3x3 import hbs_pkg::*; #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] height
	input  logic                  s_axis_tuser,  // [0] cmd (1 = flush)
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [23:0] smoothed, [32:24] out_row,
	                                             // [41:33] out_col, rest zero
	output logic                  m_axis_tlast   // frame_end
);

	localparam int COL_CNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_CNT_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int IN_ROW_W = $clog2(MAX_HEIGHT + 2);
	localparam int DW_W = $clog2(MAX_WIDTH + 1);
	localparam int DH_W = $clog2(MAX_HEIGHT + 1);
	localparam int W_RESET = (FRAME_DEFAULT > MAX_WIDTH) ? MAX_WIDTH : FRAME_DEFAULT;
	localparam int H_RESET = (FRAME_DEFAULT > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_DEFAULT;

	function automatic logic [CMP_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
		input logic [CMP_W-1:0] maxv);
		if (v == '0) begin
			return CMP_W'(1);
		end else if (CMP_W'(v) > maxv) begin
			return maxv;
		end
		return CMP_W'(v);
	endfunction

	logic [DW_W-1:0]      w_q;
	logic [DH_W-1:0]      h_q;
	logic [COL_CNT_W-1:0] in_col_q;
	logic [IN_ROW_W-1:0]  in_row_q;
	logic [COL_CNT_W-1:0] out_col_q;
	logic [ROW_CNT_W-1:0] out_row_q;

	logic [CMP_W-1:0] w_x, h_x, in_col_x, in_row_x, out_col_x, out_row_x;
	logic cfg_wr, cfg_hit, flush, complete, useful, take, emit, col_wrap, out_wrap, last;
	item_t item;

	logic win_ready, sum_valid, sum_ready;
	logic [SUM_W-1:0] sum;
	logic [CNT_W-1:0] cnt;
	tag_t sum_tag, res_tag;
	logic [MEAN_W-1:0] mean;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign cfg_hit = cfg_wr && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_comb begin
		w_x = CMP_W'(w_q);
		h_x = CMP_W'(h_q);
		in_col_x = CMP_W'(in_col_q);
		in_row_x = CMP_W'(in_row_q);
		out_col_x = CMP_W'(out_col_q);
		out_row_x = CMP_W'(out_row_q);
		flush = s_axis_tuser;
		complete = in_row_x >= h_x;
		// samples only before the frame is complete, flushes only after
		useful = (flush == complete);
		take = s_axis_tvalid && s_axis_tready && useful;
		emit = (in_row_x >= CMP_W'(2)) || (in_row_x == CMP_W'(1) && in_col_x != '0);
		col_wrap = (in_col_x + CMP_W'(1)) == w_x;
		out_wrap = (out_col_x + CMP_W'(1)) == w_x;
		item.flush = flush;
		item.emit = emit;
		item.mask.top = out_row_x != '0;
		item.mask.bot = (out_row_x + CMP_W'(1)) != h_x;
		item.mask.left = out_col_x != '0;
		item.mask.right = !out_wrap;
		last = !item.mask.bot && out_wrap;
		item.tag.row = ROW_W'(out_row_q);
		item.tag.col = COL_W'(out_col_q);
		item.tag.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= DW_W'(W_RESET);
			h_q <= DH_W'(H_RESET);
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				w_q <= DW_W'(clamp_dim(cfg_data, CMP_W'(MAX_WIDTH)));
			end else begin
				h_q <= DH_W'(clamp_dim(cfg_data, CMP_W'(MAX_HEIGHT)));
			end
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (emit && last) begin
				in_col_q <= '0;
				in_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + IN_ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_CNT_W'(1);
				end
				if (emit) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_CNT_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_CNT_W'(1);
					end
				end
			end
		end
	end

	// ignored beats are taken here and never reach the pipeline
	assign s_axis_tready = win_ready;

	hbs_window #(
		.DEPTH(MAX_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid && useful),
		.in_ready (win_ready),
		.in_item  (item),
		.in_addr  (in_col_q),
		.in_height(s_axis_tdata[HEIGHT_W-1:0]),
		.out_valid(sum_valid),
		.out_ready(sum_ready),
		.out_sum  (sum),
		.out_cnt  (cnt),
		.out_tag  (sum_tag)
	);

	hbs_mean u_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sum_valid),
		.in_ready (sum_ready),
		.in_sum   (sum),
		.in_cnt   (cnt),
		.in_tag   (sum_tag),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_mean (mean),
		.out_tag  (res_tag)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_tag.col, res_tag.row, mean};
	assign m_axis_tlast = res_tag.last;

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit && last && !cfg_hit |=> (in_row_q == '0 && in_col_q == '0 &&
			out_row_q == '0 && out_col_q == '0))
		else $error("frame did not restart after its last result");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the 3x3 heightmap box smoothing filter.
`timescale 1ns / 1ps

module tb_top;
	import hbs_pkg::*;

	localparam int FRAME_MAX_W = 512;
	localparam int FRAME_MAX_H = 512;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BEATS = 200;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

	typedef enum {FILL_RANDOM, FILL_MAX, FILL_CHECKER} fill_t;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              last;
	} smooth_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [15:0] height
	logic                  s_axis_tuser = 1'b0; // [0] cmd (1 = flush)
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // [23:0] smoothed, [32:24] row, [41:33] col
	logic                  m_axis_tlast;        // frame_end

	// filter state mirrored on the testbench side
	logic [CFG_W-1:0]    width_reg, height_reg;
	logic [HEIGHT_W-1:0] upper_line [FRAME_MAX_W];
	logic [HEIGHT_W-1:0] middle_line [FRAME_MAX_W];
	logic [HEIGHT_W-1:0] win [3][3];
	int unsigned         in_col, in_row, out_col, out_row;

	smooth_t     pending_means[$];
	int unsigned fed_beats = 0;
	int unsigned mismatches = 0;
	bit          steady = 1'b0;

	heightmap_box_smooth_3x3 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned lim);
		if (v == 0) return 1;
		if (v > lim) return lim;
		return 32'(v);
	endfunction

	function automatic void restart_position();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	function automatic void reset_filter();
		width_reg = CFG_W'(FRAME_DEFAULT);
		height_reg = CFG_W'(FRAME_DEFAULT);
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		foreach (win[r, c]) win[r][c] = '0;
		restart_position();
	endfunction

	// Advances the mirrored filter by one beat; returns 1 unless the beat is ignored.
	function automatic bit filter_step(input logic flush, input logic [HEIGHT_W-1:0] x);
		int unsigned       w, h, c, r, cc, n;
		longint unsigned   sum, mean;
		logic [HEIGHT_W-1:0] column [3];
		bit                emit, last;
		smooth_t           res;
		w = clamp_size(width_reg, FRAME_MAX_W);
		h = clamp_size(height_reg, FRAME_MAX_H);
		if (flush != (in_row >= h)) return 1'b0;
		c = (in_col >= FRAME_MAX_W) ? FRAME_MAX_W - 1 : in_col;
		column[0] = upper_line[c];
		column[1] = middle_line[c];
		column[2] = flush ? '0 : x;
		upper_line[c] = column[1];
		middle_line[c] = column[2];
		for (int dr = 0; dr < 3; dr++) begin
			win[dr][0] = win[dr][1];
			win[dr][1] = win[dr][2];
			win[dr][2] = column[dr];
		end
		emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (!emit) return 1'b1;
		r = out_row;
		cc = out_col;
		sum = 0;
		n = 0;
		// rows and columns outside the frame drop out of the mean
		for (int dr = 0; dr < 3; dr++) begin
			if ((dr == 0 && r == 0) || (dr == 2 && r + 1 >= h)) continue;
			for (int dc = 0; dc < 3; dc++) begin
				if ((dc == 0 && cc == 0) || (dc == 2 && cc + 1 >= w)) continue;
				sum += win[dr][dc];
				n++;
			end
		end
		mean = (sum * 512 + n) / (2 * n);
		last = (r + 1 >= h) && (cc + 1 >= w);
		res.mean = mean[MEAN_W-1:0];
		res.row = r[ROW_W-1:0];
		res.col = cc[COL_W-1:0];
		res.last = last;
		pending_means.push_back(res);
		if (last) begin
			restart_position();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [HEIGHT_W-1:0] pick_height();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return HEIGHT_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'(1);
			9: return CFG_W'($urandom_range(13, 24));
			default: return CFG_W'($urandom_range(2, 12));
		endcase
	endfunction

	task automatic send_item(input logic flush, input logic [HEIGHT_W-1:0] x);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= x;
		s_axis_tuser <= flush;
		do @(posedge clk); while (!s_axis_tready);
		if (filter_step(flush, x)) fed_beats++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// hold keeps cfg_valid up for a write that follows at once
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v,
		input bit hold);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (!hold) cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: begin
				width_reg = v;
				restart_position();
			end
			REG_FRAME_HEIGHT: begin
				height_reg = v;
				restart_position();
			end
			default: ;
		endcase
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, w, 1'b1);
		write_reg(REG_FRAME_HEIGHT, h, 1'b0);
	endtask

	// Sends one frame of samples, then flushes until its last result is out; a partial frame stops early, unflushed.
	// Noise: flushes mid-frame and samples after the frame is complete, both ignored.
	task automatic run_frame(input fill_t fill, input bit partial, input bit noisy);
		int unsigned         w, h, n;
		logic [HEIGHT_W-1:0] x;
		bit                  first;
		w = clamp_size(width_reg, FRAME_MAX_W);
		h = clamp_size(height_reg, FRAME_MAX_H);
		n = w * h;
		if (partial) n = $urandom_range(0, n - 1);
		for (int unsigned i = 0; i < n; i++) begin
			if (noisy && (i == 0 || $urandom_range(0, 15) == 0))
				send_item(1'b1, pick_height());
			case (fill)
				FILL_MAX: x = '1;
				FILL_CHECKER: x = i[0] ? '1 : '0;
				default: x = pick_height();
			endcase
			send_item(1'b0, x);
		end
		if (partial) return;
		first = 1'b1;
		while (in_row >= h) begin
			if (noisy && (first || $urandom_range(0, 7) == 0))
				send_item(1'b0, pick_height());
			first = 1'b0;
			send_item(1'b1, pick_height());
		end
	endtask

	// reset size is 464 wide: run into the second row for a few results
	task automatic test_default_size();
		for (int i = 0; i < FRAME_DEFAULT + 4; i++) send_item(1'b0, pick_height());
		wait_drained();
	endtask

	task automatic test_extreme_values();
		set_frame(CFG_W'(3), CFG_W'(3));
		steady = 1'b1;
		run_frame(FILL_MAX, 1'b0, 1'b0);
		steady = 1'b0;
		run_frame(FILL_CHECKER, 1'b0, 1'b1);
	endtask

	// frames of one row or column; some flushes give no result
	task automatic test_tiny_frames();
		set_frame('0, '0);
		run_frame(FILL_RANDOM, 1'b0, 1'b1);
		set_frame(CFG_W'(1), CFG_W'(3));
		run_frame(FILL_RANDOM, 1'b0, 1'b1);
		set_frame(CFG_W'(3), CFG_W'(1));
		steady = 1'b1;
		run_frame(FILL_RANDOM, 1'b0, 1'b0);
		steady = 1'b0;
		set_frame(CFG_W'(2), CFG_W'(1));
		run_frame(FILL_RANDOM, 1'b0, 1'b1);
		wait_drained();
		write_reg(REG_UNUSED, '1, 1'b0);
		run_frame(FILL_RANDOM, 1'b0, 1'b0);
	endtask

	// a register write in mid-frame starts the frame over
	task automatic test_restart();
		set_frame(CFG_W'(4), CFG_W'(4));
		for (int i = 0; i < 6; i++) send_item(1'b0, pick_height());
		wait_drained();
		write_reg(REG_FRAME_HEIGHT, CFG_W'(4), 1'b0);
		run_frame(FILL_RANDOM, 1'b0, 1'b1);
	endtask

	// an oversized width wraps rows at 512, seen in the first results, which come while the second row is fed
	task automatic test_size_limits();
		set_frame('1, CFG_W'(2));
		for (int i = 0; i < FRAME_MAX_W + 4; i++) send_item(1'b0, pick_height());
		set_frame(CFG_W'(1), '1);
		run_frame(FILL_RANDOM, 1'b0, 1'b0);
	endtask

	task automatic test_random();
		int unsigned      goal;
		logic [CFG_W-1:0] w, h;
		goal = fed_beats + RANDOM_BEATS;
		while (fed_beats < goal) begin
			wait_drained();
			w = pick_size();
			h = pick_size();
			case ($urandom_range(0, 2))
				0: write_reg(REG_FRAME_WIDTH, w, 1'b0);
				1: write_reg(REG_FRAME_HEIGHT, h, 1'b0);
				default: begin
					write_reg(REG_FRAME_WIDTH, w, 1'b1);
					write_reg(REG_FRAME_HEIGHT, h, 1'b0);
				end
			endcase
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3))
				run_frame(FILL_RANDOM, 1'b0, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 5) == 0)
				run_frame(FILL_RANDOM, 1'b1, 1'($urandom_range(0, 1)));
		end
		steady = 1'b0;
	endtask

	initial begin : receiver
		int stall;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	task automatic report_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		smooth_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_means.size() == 0) begin
				$display("%0t: result beat with none expected, expected none actual %h",
					$time, m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_means.pop_front();
				report_field("smoothed", 32'(want.mean), 32'(m_axis_tdata[MEAN_W-1:0]));
				report_field("out_row", 32'(want.row), 32'(m_axis_tdata[MEAN_W +: ROW_W]));
				report_field("out_col", 32'(want.col),
					32'(m_axis_tdata[MEAN_W+ROW_W +: COL_W]));
				report_field("frame_end", 32'(want.last), 32'(m_axis_tlast));
				report_field("tdata pad", '0, 32'(m_axis_tdata[OUT_DATA_W-1 -: OUT_PAD_W]));
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		reset_filter();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_default_size();
		test_extreme_values();
		test_tiny_frames();
		test_restart();
		test_size_limits();
		test_random();
		wait_drained();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
